[hdl/lsfs_pkg.sv]
// shared types, constants and decode tables of the lpc speech synthesizer
package lsfs_pkg;

    localparam int FILTER_ORDER           = 10;
    localparam int IDX_W                  = $clog2(FILTER_ORDER);
    localparam int SAMPLES_PER_UPDATE     = 25;
    localparam int CHIRP_LEN              = 41;
    localparam int SPEECH_STORE_DEPTH_DEF = 4096;
    localparam logic [15:0] LFSR_TAPS     = 16'hB800;
    localparam logic [9:0]  IDLE_SAMPLE   = 10'd512;
    localparam logic [3:0]  ECODE_REST    = 4'h0;
    localparam logic [3:0]  ECODE_STOP    = 4'hF;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    typedef enum logic [3:0] {
        F_ENERGY, F_REPEAT, F_PITCH,
        F_K1, F_K2, F_K3, F_K4, F_K5, F_K6, F_K7, F_K8, F_K9, F_K10
    } t_field;

    typedef enum logic [1:0] {
        MK_EXC, MK_FWD, MK_BWD
    } t_mkind;

    typedef struct packed {
        logic             wr_en;
        logic             start_en;
        logic             take_bit;
        logic             apply;
        t_field           fld;
        logic             upd_en;
        logic             first;
        logic             exc_step;
        logic             mul_en;
        t_mkind           mul_kind;
        logic [IDX_W-1:0] mul_idx;
        logic             fin;
        logic             out_load;
        logic             out_idle;
        logic             out_busy;
    } t_cmd;

    typedef struct packed {
        logic       rd_ok;
        logic [3:0] ecode;
        logic       rep;
        logic       pitch_nz;
        logic       out_full;
    } t_stat;

    localparam logic [7:0] ENERGY_TAB [16] = '{
        8'h00,8'h02,8'h03,8'h04,8'h05,8'h07,8'h0a,8'h0f,
        8'h14,8'h20,8'h29,8'h39,8'h51,8'h72,8'ha1,8'hff};
    localparam logic [7:0] PITCH_TAB [64] = '{
        8'h00,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1A,8'h1B,
        8'h1C,8'h1D,8'h1E,8'h1F,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,
        8'h29,8'h2A,8'h2B,8'h2D,8'h2F,8'h31,8'h33,8'h35,8'h36,8'h39,8'h3B,8'h3D,8'h3F,
        8'h42,8'h45,8'h47,8'h49,8'h4D,8'h4F,8'h51,8'h55,8'h57,8'h5C,8'h5F,8'h63,8'h66,
        8'h6A,8'h6E,8'h73,8'h77,8'h7B,8'h80,8'h85,8'h8A,8'h8F,8'h95,8'h9A,8'hA0};
    localparam logic [15:0] K1_TAB [32] = '{
        16'h82C0,16'h8380,16'h83C0,16'h8440,16'h84C0,16'h8540,16'h8600,16'h8780,
        16'h8880,16'h8980,16'h8AC0,16'h8C00,16'h8D40,16'h8F00,16'h90C0,16'h92C0,
        16'h9900,16'hA140,16'hAB80,16'hB840,16'hC740,16'hD8C0,16'hEBC0,16'h0000,
        16'h1440,16'h2740,16'h38C0,16'h47C0,16'h5480,16'h5EC0,16'h6700,16'h6D40};
    localparam logic [15:0] K2_TAB [32] = '{
        16'hAE00,16'hB480,16'hBB80,16'hC340,16'hCB80,16'hD440,16'hDDC0,16'hE780,
        16'hF180,16'hFBC0,16'h0600,16'h1040,16'h1A40,16'h2400,16'h2D40,16'h3600,
        16'h3E40,16'h45C0,16'h4CC0,16'h5300,16'h5880,16'h5DC0,16'h6240,16'h6640,
        16'h69C0,16'h6CC0,16'h6F80,16'h71C0,16'h73C0,16'h7580,16'h7700,16'h7E80};
    localparam logic [7:0] K3_TAB [16] = '{8'h92,8'h9F,8'hAD,8'hBA,8'hC8,8'hD5,8'hE3,8'hF0,
        8'hFE,8'h0B,8'h19,8'h26,8'h34,8'h41,8'h4F,8'h5C};
    localparam logic [7:0] K4_TAB [16] = '{8'hAE,8'hBC,8'hCA,8'hD8,8'hE6,8'hF4,8'h01,8'h0F,
        8'h1D,8'h2B,8'h39,8'h47,8'h55,8'h63,8'h71,8'h7E};
    localparam logic [7:0] K5_TAB [16] = '{8'hAE,8'hBA,8'hC5,8'hD1,8'hDD,8'hE8,8'hF4,8'hFF,
        8'h0B,8'h17,8'h22,8'h2E,8'h39,8'h45,8'h51,8'h5C};
    localparam logic [7:0] K6_TAB [16] = '{8'hC0,8'hCB,8'hD6,8'hE1,8'hEC,8'hF7,8'h03,8'h0E,
        8'h19,8'h24,8'h2F,8'h3A,8'h45,8'h50,8'h5B,8'h66};
    localparam logic [7:0] K7_TAB [16] = '{8'hB3,8'hBF,8'hCB,8'hD7,8'hE3,8'hEF,8'hFB,8'h07,
        8'h13,8'h1F,8'h2B,8'h37,8'h43,8'h4F,8'h5A,8'h66};
    localparam logic [7:0] K8_TAB [8]  = '{8'hC0,8'hD8,8'hF0,8'h07,8'h1F,8'h37,8'h4F,8'h66};
    localparam logic [7:0] K9_TAB [8]  = '{8'hC0,8'hD4,8'hE8,8'hFC,8'h10,8'h25,8'h39,8'h4D};
    localparam logic [7:0] K10_TAB [8] = '{8'hCD,8'hDF,8'hF1,8'h04,8'h16,8'h28,8'h3B,8'h4D};
    localparam logic [7:0] CHIRP_TAB [CHIRP_LEN] = '{
        8'h00,8'h2a,8'hd4,8'h32,8'hb2,8'h12,8'h25,8'h14,8'h02,8'he1,8'hc5,8'h02,8'h5f,
        8'h5a,8'h05,8'h0f,8'h26,8'hfc,8'ha5,8'ha5,8'hd6,8'hdd,8'hdc,8'hfc,8'h25,8'h2b,
        8'h22,8'h21,8'h0f,8'hff,8'hf8,8'hee,8'hed,8'hef,8'hf7,8'hf6,8'hfa,8'h00,8'h03,
        8'h02,8'h01};

    function automatic logic [2:0] fld_width(t_field f);
        logic [2:0] w;
        case (f) inside
            F_ENERGY:                   w = 3'd4;
            F_REPEAT:                   w = 3'd1;
            F_PITCH:                    w = 3'd6;
            F_K1, F_K2:                 w = 3'd5;
            F_K3, F_K4, F_K5, F_K6, F_K7: w = 3'd4;
            default:                    w = 3'd3;
        endcase
        return w;
    endfunction

    function automatic logic [15:0] coef_value(t_field f, logic [4:0] c);
        logic [15:0] v;
        case (f)
            F_K1:    v = K1_TAB[c];
            F_K2:    v = K2_TAB[c];
            F_K3:    v = {K3_TAB[c[3:0]], 8'h00};
            F_K4:    v = {K4_TAB[c[3:0]], 8'h00};
            F_K5:    v = {K5_TAB[c[3:0]], 8'h00};
            F_K6:    v = {K6_TAB[c[3:0]], 8'h00};
            F_K7:    v = {K7_TAB[c[3:0]], 8'h00};
            F_K8:    v = {K8_TAB[c[2:0]], 8'h00};
            F_K9:    v = {K9_TAB[c[2:0]], 8'h00};
            default: v = {K10_TAB[c[2:0]], 8'h00};
        endcase
        return v;
    endfunction

endpackage

[hdl/lsfs_in_if.sv]
// input channel: command beats with kind, address and data byte
interface lsfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [11:0] address;
    logic [7:0] data_byte;

    modport source(output valid, output kind, output address, output data_byte, input ready);
    modport sink(input valid, input kind, input address, input data_byte, output ready);
endinterface

[hdl/lsfs_out_if.sv]
// output channel: sample beats
interface lsfs_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] sample;
    logic       busy_res;

    modport source(output valid, output sample, output busy_res, input ready);
    modport sink(input valid, input sample, input busy_res, output ready);
endinterface

[hdl/lsfs_datapath.sv]
// datapath: speech store, bit reader, parameter registers, shared multiplier, lattice
module lsfs_datapath
    import lsfs_pkg::*;
#(
    parameter int SPEECH_STORE_DEPTH = SPEECH_STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_ready,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [9:0]  o_out_sample,
    output logic        o_out_busy
);
    localparam int AW = $clog2(SPEECH_STORE_DEPTH);

    logic [7:0]    r_mem [SPEECH_STORE_DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_ptr;
    logic [2:0]    r_bitpos;
    logic          r_rd_ok;
    logic [5:0]    r_field;
    logic [3:0]    r_ecode;
    logic          r_rep;

    logic [7:0]  r_tgt_pitch, r_cur_pitch, r_tgt_energy, r_cur_energy, r_phase;
    logic [15:0] r_lfsr;
    logic signed [15:0] r_tgt_coef [FILTER_ORDER];
    logic signed [15:0] r_cur_coef [FILTER_ORDER];
    logic signed [15:0] r_taps [FILTER_ORDER];
    logic signed [15:0] r_fwd [FILTER_ORDER];
    logic signed [15:0] r_acc;
    logic signed [31:0] r_prod;
    logic               r_pend_en;
    t_mkind             r_pend_kind;
    logic [IDX_W-1:0]   r_pend_idx;

    logic          r_out_valid;
    logic [9:0]    r_out_sample;
    logic          r_out_busy;

    logic          w_bit;
    logic [5:0]    w_val;
    logic [AW-1:0] w_addr;
    logic signed [15:0] w_mul_a, w_mul_b, w_exc_a, w_fwd_v, w_fwd_clamped;
    logic [IDX_W-1:0]   w_prev;
    logic [IDX_W-1:0]   w_kidx;

    assign w_bit  = r_rdata[r_bitpos];
    assign w_val  = {r_field[4:0], w_bit};
    assign w_addr = AW'(i_address);
    assign w_prev = i_cmd.mul_idx - 1'b1;
    assign w_kidx = IDX_W'(i_cmd.fld - F_K1);

    // speech store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_addr] <= i_data_byte;
        end
        r_rdata <= r_mem[r_ptr];
    end

    // excitation operand: chirp sample (zero past the chirp end) or +/-256 for noise
    always_comb begin
        if (r_cur_pitch != 8'd0) begin
            if (r_phase < 8'(CHIRP_LEN)) begin
                w_exc_a = 16'(signed'(CHIRP_TAB[r_phase[5:0]]));
            end else begin
                w_exc_a = '0;
            end
        end else begin
            w_exc_a = r_lfsr[0] ? 16'sd256 : -16'sd256;
        end
    end

    always_comb begin
        case (i_cmd.mul_kind)
            MK_FWD: begin
                w_mul_a = r_cur_coef[i_cmd.mul_idx];
                w_mul_b = r_taps[i_cmd.mul_idx];
            end
            MK_BWD: begin
                w_mul_a = r_cur_coef[w_prev];
                w_mul_b = r_fwd[w_prev];
            end
            default: begin
                w_mul_a = w_exc_a;
                w_mul_b = signed'({8'd0, r_cur_energy});
            end
        endcase
    end

    assign w_fwd_v = r_acc - 16'(r_prod >>> 15);
    always_comb begin
        if (w_fwd_v > 16'sd511) begin
            w_fwd_clamped = 16'sd511;
        end else if (w_fwd_v < -16'sd512) begin
            w_fwd_clamped = -16'sd512;
        end else begin
            w_fwd_clamped = w_fwd_v;
        end
    end

    // shared multiplier and lattice accumulation in the cycle after each product
    always_ff @(posedge i_clk) begin
        r_prod      <= w_mul_a * w_mul_b;
        r_pend_kind <= i_cmd.mul_kind;
        r_pend_idx  <= i_cmd.mul_idx;
        if (r_pend_en) begin
            case (r_pend_kind)
                MK_EXC: r_acc <= 16'(r_prod >>> 8);
                MK_FWD: begin
                    r_acc <= w_fwd_v;
                    r_fwd[r_pend_idx] <= (r_pend_idx == '0) ? w_fwd_clamped : w_fwd_v;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_bitpos     <= '0;
            r_rd_ok      <= 1'b0;
            r_field      <= '0;
            r_ecode      <= '0;
            r_rep        <= 1'b0;
            r_tgt_pitch  <= '0;
            r_cur_pitch  <= '0;
            r_tgt_energy <= '0;
            r_cur_energy <= '0;
            r_phase      <= '0;
            r_lfsr       <= 16'd1;
            r_pend_en    <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < FILTER_ORDER; i++) begin
                r_tgt_coef[i] <= '0;
                r_cur_coef[i] <= '0;
                r_taps[i]     <= '0;
            end
        end else begin
            r_pend_en <= i_cmd.mul_en;
            r_rd_ok   <= !(i_cmd.wr_en || i_cmd.start_en ||
                           (i_cmd.take_bit && r_bitpos == 3'd7));
            if (i_cmd.start_en) begin
                r_ptr    <= w_addr;
                r_bitpos <= '0;
            end
            // bit reader, lsb first, first bit lands in the field msb
            if (i_cmd.take_bit) begin
                r_field  <= i_cmd.apply ? 6'd0 : w_val;
                r_bitpos <= r_bitpos + 3'd1;
                if (r_bitpos == 3'd7) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_cmd.apply) begin
                case (i_cmd.fld)
                    F_ENERGY: begin
                        r_ecode <= w_val[3:0];
                        if (w_val[3:0] == ECODE_STOP) begin
                            r_tgt_energy <= '0;
                            for (int i = 0; i < FILTER_ORDER; i++) begin
                                r_tgt_coef[i] <= '0;
                            end
                        end else if (w_val[3:0] == ECODE_REST) begin
                            r_tgt_energy <= '0;
                        end else begin
                            r_tgt_energy <= ENERGY_TAB[w_val[3:0]];
                        end
                    end
                    F_REPEAT: r_rep       <= w_val[0];
                    F_PITCH:  r_tgt_pitch <= PITCH_TAB[w_val];
                    default:  r_tgt_coef[w_kidx] <= coef_value(i_cmd.fld, w_val[4:0]);
                endcase
            end
            // exponential approach to targets, a quarter of the distance; the first update after start copies them
            if (i_cmd.upd_en) begin
                if (i_cmd.first) begin
                    r_cur_pitch  <= r_tgt_pitch;
                    r_cur_energy <= r_tgt_energy;
                    for (int i = 0; i < FILTER_ORDER; i++) begin
                        r_cur_coef[i] <= r_tgt_coef[i];
                    end
                end else begin
                    r_cur_pitch  <= r_cur_pitch +
                        8'(($signed({1'b0, r_tgt_pitch}) - $signed({1'b0, r_cur_pitch})) >>> 2);
                    r_cur_energy <= r_cur_energy +
                        8'(($signed({1'b0, r_tgt_energy}) - $signed({1'b0, r_cur_energy})) >>> 2);
                    for (int i = 0; i < FILTER_ORDER; i++) begin
                        r_cur_coef[i] <= r_cur_coef[i] + 16'(($signed({r_tgt_coef[i][15],
                            r_tgt_coef[i]}) - $signed({r_cur_coef[i][15], r_cur_coef[i]})) >>> 2);
                    end
                end
            end
            if (i_cmd.exc_step) begin
                if (r_cur_pitch != 8'd0) begin
                    r_phase <= (r_phase < r_cur_pitch) ? r_phase + 8'd1 : 8'd0;
                end else begin
                    r_lfsr <= (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
                end
            end
            if (r_pend_en && r_pend_kind == MK_BWD) begin
                r_taps[r_pend_idx] <= r_taps[r_pend_idx - 1'b1] + 16'(r_prod >>> 15);
            end
            if (i_cmd.fin) begin
                r_taps[0] <= r_fwd[0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= i_cmd.out_idle ? IDLE_SAMPLE : 10'(r_fwd[0] + 16'sd512);
            r_out_busy   <= i_cmd.out_busy;
        end
    end

    assign o_stat.rd_ok    = r_rd_ok;
    assign o_stat.ecode    = r_ecode;
    assign o_stat.rep      = r_rep;
    assign o_stat.pitch_nz = (r_tgt_pitch != 8'd0);
    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_busy   = r_out_busy;
endmodule

[hdl/lsfs_ctrl.sv]
// controller: sample and frame counters, frame parse sequence, lattice step sequence
module lsfs_ctrl
    import lsfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_kind,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_PARSE  = 11'b000_0000_0010,
        S_PDEC   = 11'b000_0000_0100,
        S_UPD    = 11'b000_0000_1000,
        S_EXC    = 11'b000_0001_0000,
        S_EXC2   = 11'b000_0010_0000,
        S_FWD    = 11'b000_0100_0000,
        S_BWD    = 11'b000_1000_0000,
        S_FIN    = 11'b001_0000_0000,
        S_OUTW   = 11'b010_0000_0000,
        S_IDLOUT = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic             r_running, n_running;
    logic             r_first, n_first;
    logic [4:0]       r_sc, n_sc;
    logic [2:0]       r_sub, n_sub;
    t_field           r_fld, n_fld;
    logic [2:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0] r_j, n_j;
    logic [4:0]       w_sc_inc;
    logic [2:0]       w_sub_inc;

    assign w_sc_inc  = r_sc + 5'd1;
    assign w_sub_inc = r_sub + 3'd1;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_running = r_running;
        n_first   = r_first;
        n_sc      = r_sc;
        n_sub     = r_sub;
        n_fld     = r_fld;
        n_cnt     = r_cnt;
        n_j       = r_j;
        o_cmd     = '0;
        o_cmd.fld = r_fld;
        o_cmd.mul_idx = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_kind)
                        KIND_WRITE: o_cmd.wr_en = 1'b1;
                        KIND_START: begin
                            o_cmd.start_en = 1'b1;
                            n_running = 1'b1;
                            n_first   = 1'b1;
                        end
                        KIND_TICK: begin
                            if (!r_running) begin
                                n_state = S_IDLOUT;
                            end else if (w_sc_inc >= 5'(SAMPLES_PER_UPDATE)) begin
                                n_sc  = '0;
                                n_sub = w_sub_inc;
                                if (w_sub_inc == 3'd0) begin
                                    n_state = S_PARSE;
                                    n_fld   = F_ENERGY;
                                    n_cnt   = '0;
                                end else begin
                                    n_state = S_UPD;
                                end
                            end else begin
                                n_sc    = w_sc_inc;
                                n_state = S_EXC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PARSE: begin
                if (i_stat.rd_ok) begin
                    o_cmd.take_bit = 1'b1;
                    if (r_cnt == fld_width(r_fld) - 3'd1) begin
                        o_cmd.apply = 1'b1;
                        n_cnt   = '0;
                        n_state = S_PDEC;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            S_PDEC: begin
                n_state = S_PARSE;
                n_fld   = t_field'(r_fld + 4'd1);
                case (r_fld)
                    F_ENERGY: begin
                        if (i_stat.ecode == ECODE_REST) begin
                            n_state = S_UPD;
                        end else if (i_stat.ecode == ECODE_STOP) begin
                            n_state   = S_UPD;
                            n_running = 1'b0;
                        end
                    end
                    F_PITCH: if (i_stat.rep) n_state = S_UPD;
                    F_K4:    if (!i_stat.pitch_nz) n_state = S_UPD;
                    F_K10:   n_state = S_UPD;
                    default: ;
                endcase
            end
            S_UPD: begin
                o_cmd.upd_en = 1'b1;
                o_cmd.first  = r_first;
                n_first = 1'b0;
                n_state = S_EXC;
            end
            S_EXC: begin
                o_cmd.exc_step = 1'b1;
                n_state = S_EXC2;
            end
            S_EXC2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_kind = MK_EXC;
                n_j     = IDX_W'(FILTER_ORDER - 1);
                n_state = S_FWD;
            end
            S_FWD: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_kind = MK_FWD;
                if (r_j == '0) begin
                    n_j     = IDX_W'(FILTER_ORDER - 1);
                    n_state = S_BWD;
                end else begin
                    n_j = r_j - 1'b1;
                end
            end
            S_BWD: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_kind = MK_BWD;
                if (r_j == IDX_W'(1)) begin
                    n_state = S_FIN;
                end else begin
                    n_j = r_j - 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_OUTW;
            end
            S_OUTW: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_busy = r_running;
                    n_state = S_IDLE;
                end
            end
            S_IDLOUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_idle = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= 1'b0;
            r_first   <= 1'b0;
            r_sc      <= '0;
            r_sub     <= '0;
            r_fld     <= F_ENERGY;
            r_cnt     <= '0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_first   <= n_first;
            r_sc      <= n_sc;
            r_sub     <= n_sub;
            r_fld     <= n_fld;
            r_cnt     <= n_cnt;
            r_j       <= n_j;
        end
    end

    a_stop_only_in_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |-> $past(r_state) == S_PDEC)
        else $error("running cleared outside frame decode");
    a_bit_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_bit |-> i_stat.rd_ok)
        else $error("bit taken from stale store data");
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc < 5'(SAMPLES_PER_UPDATE))
        else $error("sample counter out of range");
    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_stat.out_full)
        else $error("output register overwritten");
endmodule

[hdl/lpc_speech_frame_synth.sv]
// top level of the ten-stage lpc lattice speech synthesizer
// usage:
//   i_in carries command beats: kind 0 writes data_byte into the speech store at
//   address, kind 1 starts an utterance at address, kind 2 asks for one sample.
//   kind 3 is dropped. only a sample request yields a beat on o_out.
//   o_out carries the sample (10-bit offset binary, 512 when idle) and busy_res,
//   high while the utterance still runs after this sample.
// sequence:
//   write and start are taken in the idle state. a running sample passes through
//   the beat, excitation step, excitation product, ten forward and nine backward
//   lattice products through one shared 16x16 multiplier, tap finish and output load.
//   every 25th sample adds a parameter update, and every 200th also parses a frame
//   bit by bit, with a decode step after each field and a wait for each byte
//   boundary crossed.
// reset: synchronous, active low; clears the reader, counters, parameters and
//   lattice taps, seeds the noise register with one. the store is not cleared.
// stall: the result waits in an output register; the next command is taken
//   meanwhile, and a further sample waits until the register is free.
module lpc_speech_frame_synth
    import lsfs_pkg::*;
#(
    parameter int SPEECH_STORE_DEPTH = SPEECH_STORE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsfs_in_if.sink   i_in,
    lsfs_out_if.source o_out
);
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing of each beat
    lsfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // store, parameters, multiplier and output register
    lsfs_datapath #(
        .SPEECH_STORE_DEPTH (SPEECH_STORE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_address    (i_in.address),
        .i_data_byte  (i_in.data_byte),
        .i_out_ready  (o_out.ready),
        .o_stat       (w_stat),
        .o_out_valid  (o_out.valid),
        .o_out_sample (o_out.sample),
        .o_out_busy   (o_out.busy_res)
    );
endmodule
